// ===== rtl/qrm_pkg.sv =====
package qrm_pkg;

  localparam int unsigned Lanes = 9;
  localparam int unsigned QuoBits = 15;
  localparam int unsigned RemBits = 48;
  localparam int unsigned DenBits = 34;
  localparam logic [QuoBits-1:0] OneQ14 = 15'd16384;

  typedef struct packed {
    logic                                 vld;
    logic                                 zero;
    logic [Lanes-1:0]                     neg;
    logic [Lanes-1:0][RemBits-1:0]        rem;
    logic [Lanes-1:0][QuoBits-1:0]        quo;
    logic [DenBits-1:0]                   den;
    logic [2:0][31:0]                     shift;
  } div_word_t;

endpackage

// ===== rtl/qrm_div_step.sv =====
module qrm_div_step #(
  parameter int unsigned BIT = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  qrm_pkg::div_word_t d,
  output qrm_pkg::div_word_t q
);

  logic [qrm_pkg::RemBits-1:0] trial;
  qrm_pkg::div_word_t nxt;

  assign trial = qrm_pkg::RemBits'(d.den) << BIT;

  always_comb begin
    nxt = d;
    nxt.vld = d.vld & ~rst;
    for (int i = 0; i < qrm_pkg::Lanes; i++) begin
      if (d.rem[i] >= trial) begin
        nxt.rem[i] = d.rem[i] - trial;
        nxt.quo[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= nxt;
  end

endmodule

// ===== rtl/quaternion_to_rotation_matrix_core.sv =====
// Quaternion (Q2.14) to 3x3 rotation matrix (Q2.14), normalized by the
// squared norm so any nonzero quaternion works; a zero quaternion yields a
// zero rotation. The translation words ride along unchanged. A pose is taken
// every cycle (busy stays low); its result appears with done after passing
// through 19 register stages: one product stage, one sum stage, one setup
// stage, fifteen restoring divide stages (one quotient bit each, nine lanes
// sharing the divisor) and the output register. The receiver must take each
// word as it appears.
module quaternion_to_rotation_matrix_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  output logic               done,
  output logic signed [15:0] rot_00,
  output logic signed [15:0] rot_01,
  output logic signed [15:0] rot_02,
  output logic signed [15:0] rot_10,
  output logic signed [15:0] rot_11,
  output logic signed [15:0] rot_12,
  output logic signed [15:0] rot_20,
  output logic signed [15:0] rot_21,
  output logic signed [15:0] rot_22,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  localparam int unsigned Steps = qrm_pkg::QuoBits;

  assign busy = 1'b0;

  // products
  logic               v1;
  logic signed [31:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  logic [2:0][31:0]   sh1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    ww <= quat_w * quat_w;
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
    wx <= quat_w * quat_x;
    wy <= quat_w * quat_y;
    wz <= quat_w * quat_z;
    xy <= quat_x * quat_y;
    xz <= quat_x * quat_z;
    yz <= quat_y * quat_z;
    sh1 <= {shift_z, shift_y, shift_x};
  end

  // sums
  logic                    v2;
  logic [32:0]             nrm;
  logic signed [8:0][33:0] num;
  logic [2:0][31:0]        sh2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    nrm <= 33'(ww) + 33'(xx) + 33'(yy) + 33'(zz);
    num[0] <= 34'(ww) + 34'(xx) - 34'(yy) - 34'(zz);
    num[1] <= (34'(wz) + 34'(xy)) <<< 1;
    num[2] <= (34'(xz) - 34'(wy)) <<< 1;
    num[3] <= (34'(xy) - 34'(wz)) <<< 1;
    num[4] <= 34'(ww) - 34'(xx) + 34'(yy) - 34'(zz);
    num[5] <= (34'(wx) + 34'(yz)) <<< 1;
    num[6] <= (34'(wy) + 34'(xz)) <<< 1;
    num[7] <= (34'(yz) - 34'(wx)) <<< 1;
    num[8] <= 34'(ww) - 34'(xx) - 34'(yy) + 34'(zz);
    sh2 <= sh1;
  end

  // divider setup: rem = |num|*2^15 + n, den = 2n
  qrm_pkg::div_word_t st [Steps+1];
  qrm_pkg::div_word_t setup;

  always_comb begin
    logic [33:0] mag;
    setup = '0;
    setup.vld = v2 & ~rst;
    setup.zero = (nrm == '0);
    setup.den = {1'b0, nrm} << 1;
    setup.shift = sh2;
    for (int i = 0; i < qrm_pkg::Lanes; i++) begin
      setup.neg[i] = num[i][33];
      mag = num[i][33] ? (34'd0 - num[i]) : num[i];
      setup.rem[i] = (qrm_pkg::RemBits'(mag[32:0]) << 15) + qrm_pkg::RemBits'(nrm);
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= setup;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div
    qrm_div_step #(.BIT(Steps - 1 - k)) u_step (
      .clk (clk),
      .rst (rst),
      .d   (st[k]),
      .q   (st[k+1])
    );
  end

  // output
  logic [8:0][15:0] elem;

  always_comb begin
    logic [14:0] qs;
    for (int i = 0; i < qrm_pkg::Lanes; i++) begin
      qs = (st[Steps].quo[i] > qrm_pkg::OneQ14) ? qrm_pkg::OneQ14 : st[Steps].quo[i];
      if (st[Steps].zero) begin
        elem[i] = '0;
      end else if (st[Steps].neg[i]) begin
        elem[i] = 16'd0 - {1'b0, qs};
      end else begin
        elem[i] = {1'b0, qs};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st[Steps].vld;
    end
    rot_00 <= elem[0];
    rot_01 <= elem[1];
    rot_02 <= elem[2];
    rot_10 <= elem[3];
    rot_11 <= elem[4];
    rot_12 <= elem[5];
    rot_20 <= elem[6];
    rot_21 <= elem[7];
    rot_22 <= elem[8];
    out_x <= st[Steps].shift[0];
    out_y <= st[Steps].shift[1];
    out_z <= st[Steps].shift[2];
  end

  a_last_to_done: assert property (@(posedge clk) disable iff (rst)
    st[Steps].vld |=> done) else $error("result word dropped");
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !st[Steps].vld |=> !done) else $error("result word invented");
  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rot_00 <= 16'sd16384 && rot_00 >= -16'sd16384 &&
              rot_11 <= 16'sd16384 && rot_11 >= -16'sd16384 &&
              rot_22 <= 16'sd16384 && rot_22 >= -16'sd16384))
    else $error("diagonal out of range");

endmodule
